[rtl/raster_stretch_to_premul_bgra_macros.svh]
// Assertion macros used by the raster stretch top level.
`ifndef RASTER_STRETCH_TO_PREMUL_BGRA_MACROS_SVH
`define RASTER_STRETCH_TO_PREMUL_BGRA_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RSP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/rsp_pkg.sv]
// Shared types, constants and helper functions for the raster stretch pipeline.
package rsp_pkg;

    localparam int NUM_LANES  = 3;
    localparam int NUM_STAGES = 5;
    localparam int SAMPLE_W   = 32;
    localparam int GAIN_W     = 32;
    localparam int PIX_W      = 8;
    localparam int MODE_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int EXT_W      = 34;

    // Mode register bit positions
    localparam int MODE_STRETCH = 0;
    localparam int MODE_COLOR   = 1;
    localparam int MODE_NODATA  = 2;

    // Pipeline stage positions
    localparam int ST_DIFF   = 0;
    localparam int ST_MUL    = 1;
    localparam int ST_SAT    = 2;
    localparam int ST_PREMUL = 3;
    localparam int ST_OUT    = 4;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 32'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE       = 3'd0,
        CFG_NODATA     = 3'd1,
        CFG_RED_LOW    = 3'd2,
        CFG_RED_GAIN   = 3'd3,
        CFG_GREEN_LOW  = 3'd4,
        CFG_GREEN_GAIN = 3'd5,
        CFG_BLUE_LOW   = 3'd6,
        CFG_BLUE_GAIN  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
    } t_pipe_ctl;

    // Clamp a sign-extended value to 0..255
    function automatic logic [PIX_W-1:0] clamp_byte(input logic [EXT_W-1:0] v);
        logic [PIX_W-1:0] res;
        if (v[EXT_W-1]) begin
            res = '0;
        end else if (|v[EXT_W-2:PIX_W]) begin
            res = '1;
        end else begin
            res = v[PIX_W-1:0];
        end
        return res;
    endfunction

    // floor(x / 255) for x up to 255 * 255
    function automatic logic [PIX_W-1:0] div255(input logic [2*PIX_W-1:0] x);
        logic [2*PIX_W:0] t;
        t = {1'b0, x} + 17'd1 + {9'd0, x[2*PIX_W-1:PIX_W]};
        return t[2*PIX_W-1:PIX_W];
    endfunction

endpackage

[rtl/rsp_lane.sv]
// One color lane: offset, gain multiply and saturation of a band sample, or a plain clamp when stretch is off.
module rsp_lane
    import rsp_pkg::*;
#(
    parameter int SAMPLE_BITS    = 32,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  t_pipe_ctl           i_ctl,
    input  logic                i_stretch,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic [SAMPLE_W-1:0] i_low,
    input  logic [GAIN_W-1:0]   i_gain,
    output logic [PIX_W-1:0]    o_byte
);

    logic [EXT_W-1:0]         w_sext;
    logic [EXT_W-1:0]         w_diff;

    logic                     r_pos;
    logic [SAMPLE_W-1:0]      r_mag;
    logic [PIX_W-1:0]         r_clamp0;
    logic [GAIN_W-1:0]        r_gain;

    logic                     r_pos1;
    logic [PIX_W-1:0]         r_clamp1;
    logic [SAMPLE_W+GAIN_W-1:0] r_prod;

    logic [PIX_W-1:0]         n_byte;
    logic [PIX_W-1:0]         r_byte;

    assign w_sext = {{(EXT_W-SAMPLE_BITS){i_sample[SAMPLE_BITS-1]}},
                     i_sample[SAMPLE_BITS-1:0]};
    assign w_diff = w_sext - {{(EXT_W-SAMPLE_W){i_low[SAMPLE_W-1]}}, i_low};

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[ST_DIFF]) begin
            r_pos    <= !w_diff[EXT_W-1] && (|w_diff);
            r_mag    <= w_diff[SAMPLE_W-1:0];
            r_clamp0 <= clamp_byte(w_sext);
            r_gain   <= i_gain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[ST_MUL]) begin
            r_pos1   <= r_pos;
            r_clamp1 <= r_clamp0;
            r_prod   <= {{GAIN_W{1'b0}}, r_mag} * {{SAMPLE_W{1'b0}}, r_gain};
        end
    end

    // In stretch mode, zero a non-positive difference, drop the fraction bits, saturate anything above one byte
    always_comb begin
        if (!i_stretch) begin
            n_byte = r_clamp1;
        end else if (!r_pos1) begin
            n_byte = '0;
        end else if (|r_prod[SAMPLE_W+GAIN_W-1:GAIN_FRAC_BITS+PIX_W]) begin
            n_byte = '1;
        end else begin
            n_byte = r_prod[GAIN_FRAC_BITS+PIX_W-1:GAIN_FRAC_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[ST_SAT]) begin
            r_byte <= n_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

[rtl/rsp_merge.sv]
// Merge stage: alpha decision, gray/color selection and premultiply.
module rsp_merge
    import rsp_pkg::*;
#(
    parameter int SAMPLE_BITS = 32
) (
    input  logic                i_clk,
    input  t_pipe_ctl           i_ctl,
    input  logic [MODE_W-1:0]   i_mode,
    input  logic [SAMPLE_W-1:0] i_nodata,
    input  logic [SAMPLE_W-1:0] i_sample_red,
    input  logic [SAMPLE_W-1:0] i_alpha_sample,
    input  logic                i_alpha_present,
    input  logic [PIX_W-1:0]    i_lane_byte [NUM_LANES],
    output logic [4*PIX_W-1:0]  o_pixel
);

    logic [EXT_W-1:0]   w_red;
    logic [EXT_W-1:0]   w_alpha;
    logic [PIX_W-1:0]   n_alpha;
    logic [PIX_W-1:0]   w_green;
    logic [PIX_W-1:0]   w_blue;

    logic [PIX_W-1:0]   r_alpha [ST_PREMUL];
    logic [2*PIX_W-1:0] r_prod_b;
    logic [2*PIX_W-1:0] r_prod_g;
    logic [2*PIX_W-1:0] r_prod_r;
    logic [PIX_W-1:0]   r_alpha_p;
    logic [4*PIX_W-1:0] r_pixel;

    assign w_red   = {{(EXT_W-SAMPLE_BITS){i_sample_red[SAMPLE_BITS-1]}},
                      i_sample_red[SAMPLE_BITS-1:0]};
    assign w_alpha = {{(EXT_W-SAMPLE_BITS){i_alpha_sample[SAMPLE_BITS-1]}},
                      i_alpha_sample[SAMPLE_BITS-1:0]};

    // A present alpha sample overrides the nodata decision
    always_comb begin
        if (i_alpha_present) begin
            n_alpha = clamp_byte(w_alpha);
        end else if (i_mode[MODE_NODATA] && (w_red[SAMPLE_W-1:0] == i_nodata)) begin
            n_alpha = '0;
        end else begin
            n_alpha = '1;
        end
    end

    // Hold alpha alongside the lanes until premultiply
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[ST_DIFF]) begin
            r_alpha[ST_DIFF] <= n_alpha;
        end
        if (i_ctl.en[ST_MUL]) begin
            r_alpha[ST_MUL] <= r_alpha[ST_DIFF];
        end
        if (i_ctl.en[ST_SAT]) begin
            r_alpha[ST_SAT] <= r_alpha[ST_MUL];
        end
    end

    assign w_green = i_mode[MODE_COLOR] ? i_lane_byte[1] : i_lane_byte[0];
    assign w_blue  = i_mode[MODE_COLOR] ? i_lane_byte[2] : i_lane_byte[0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[ST_PREMUL]) begin
            r_prod_b  <= {{PIX_W{1'b0}}, w_blue} * {{PIX_W{1'b0}}, r_alpha[ST_SAT]};
            r_prod_g  <= {{PIX_W{1'b0}}, w_green} * {{PIX_W{1'b0}}, r_alpha[ST_SAT]};
            r_prod_r  <= {{PIX_W{1'b0}}, i_lane_byte[0]} * {{PIX_W{1'b0}}, r_alpha[ST_SAT]};
            r_alpha_p <= r_alpha[ST_SAT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[ST_OUT]) begin
            r_pixel <= {r_alpha_p, div255(r_prod_r), div255(r_prod_g), div255(r_prod_b)};
        end
    end

    assign o_pixel = r_pixel;

endmodule

[rtl/raster_stretch_to_premul_bgra.sv]
// Top level: contrast stretch of a raster pixel into premultiplied BGRA.
//
//   Channel   Direction  Ports                     Payload
//   s_axis    in         tvalid/tready/tdata/tuser  one raster pixel
//   m_axis    out        tvalid/tready/tdata        one BGRA pixel
//   cfg       in         i_cfg_we/idx/data          register write, no read-back
//
// One pixel per clock sustained while m_axis_tready is high, through a five-stage
// pipeline whose widest step is the 32x32 gain multiply in each color lane.
// Reset clears the stage valid bits and loads the register defaults.
// A stage holds only when it is occupied and the stage after it holds, so
// bubbles collapse and input is taken while a finished pixel waits on m_axis.
module raster_stretch_to_premul_bgra
    import rsp_pkg::*;
#(
    parameter int SAMPLE_BITS    = 32,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // sample_red, sample_green, sample_blue, alpha_sample
    input  logic [4*SAMPLE_W-1:0] s_axis_tdata,
    // alpha_present
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // out_blue, out_green, out_red, out_alpha
    output logic [4*PIX_W-1:0]    m_axis_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    `include "raster_stretch_to_premul_bgra_macros.svh"

    logic [MODE_W-1:0]     r_mode;
    logic [SAMPLE_W-1:0]   r_nodata;
    logic [SAMPLE_W-1:0]   r_low  [NUM_LANES];
    logic [GAIN_W-1:0]     r_gain [NUM_LANES];

    logic [NUM_STAGES-1:0] r_vld;
    t_pipe_ctl             w_ctl;
    logic [PIX_W-1:0]      w_lane_byte [NUM_LANES];

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= '0;
            r_nodata <= '0;
            for (int k = 0; k < NUM_LANES; k++) begin
                r_low[k]  <= '0;
                r_gain[k] <= GAIN_RESET;
            end
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MODE:       r_mode    <= i_cfg_data[MODE_W-1:0];
                CFG_NODATA:     r_nodata  <= i_cfg_data;
                CFG_RED_LOW:    r_low[0]  <= i_cfg_data;
                CFG_RED_GAIN:   r_gain[0] <= i_cfg_data;
                CFG_GREEN_LOW:  r_low[1]  <= i_cfg_data;
                CFG_GREEN_GAIN: r_gain[1] <= i_cfg_data;
                CFG_BLUE_LOW:   r_low[2]  <= i_cfg_data;
                CFG_BLUE_GAIN:  r_gain[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Advance a stage when it is empty or the next stage advances
    always_comb begin
        w_ctl.en[ST_OUT] = !r_vld[ST_OUT] || m_axis_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            w_ctl.en[k] = !r_vld[k] || w_ctl.en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_ctl.en[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (w_ctl.en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        rsp_lane #(
            .SAMPLE_BITS    (SAMPLE_BITS),
            .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
        ) u_lane (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_stretch (r_mode[MODE_STRETCH]),
            .i_sample  (s_axis_tdata[g*SAMPLE_W +: SAMPLE_W]),
            .i_low     (r_low[g]),
            .i_gain    (r_gain[g]),
            .o_byte    (w_lane_byte[g])
        );
    end

    rsp_merge #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_merge (
        .i_clk           (i_clk),
        .i_ctl           (w_ctl),
        .i_mode          (r_mode),
        .i_nodata        (r_nodata),
        .i_sample_red    (s_axis_tdata[0 +: SAMPLE_W]),
        .i_alpha_sample  (s_axis_tdata[3*SAMPLE_W +: SAMPLE_W]),
        .i_alpha_present (s_axis_tuser),
        .i_lane_byte     (w_lane_byte),
        .o_pixel         (m_axis_tdata)
    );

    assign s_axis_tready = w_ctl.en[0];
    assign m_axis_tvalid = r_vld[ST_OUT];

    `RSP_ASSERT_NEXT(a_accept_fills_first_stage, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready, r_vld[ST_DIFF], "accepted transaction lost at entry")
    `RSP_ASSERT_IMPLY(a_transparent_is_black, i_clk, i_rst_n,
        m_axis_tvalid && (m_axis_tdata[31:24] == 8'd0), m_axis_tdata[23:0] == 24'd0,
        "nonzero color with zero alpha")
    `RSP_ASSERT_IMPLY(a_premul_bounded, i_clk, i_rst_n, m_axis_tvalid,
        (m_axis_tdata[7:0] <= m_axis_tdata[31:24]) && (m_axis_tdata[15:8] <= m_axis_tdata[31:24])
        && (m_axis_tdata[23:16] <= m_axis_tdata[31:24]), "premultiplied color above alpha")

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the raster contrast stretch to premultiplied BGRA pipeline.
module tb_top;
    import rsp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS = 16;
    localparam int LONG_HOLD = 300;

    typedef struct {
        logic signed [31:0] red;
        logic signed [31:0] green;
        logic signed [31:0] blue;
        logic signed [31:0] alpha;
        logic               present;
    } t_pixel;

    // Same layout as m_axis_tdata: blue in the lowest byte.
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_bgra;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // sample_red, sample_green, sample_blue, alpha_sample
    logic [4*SAMPLE_W-1:0] s_axis_tdata = '0;
    // alpha_present
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // out_blue, out_green, out_red, out_alpha
    logic [4*PIX_W-1:0]    m_axis_tdata;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    raster_stretch_to_premul_bgra u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // Register shadow, at reset values
    logic [2:0]         mode_reg = '0;
    logic signed [31:0] nodata_reg = '0;
    logic signed [31:0] low_reg[3] = '{32'sd0, 32'sd0, 32'sd0};
    logic [31:0]        gain_reg[3] = '{GAIN_RESET, GAIN_RESET, GAIN_RESET};
    int unsigned        span_reg[3] = '{255, 255, 255};

    t_pixel pix_q[$];
    t_bgra  bgra_q[$];
    t_pixel cur_pix;
    int     n_errors = 0;
    bit     gaps_on = 1'b1;
    int     hold_req = 0;
    int     hold_done = 0;
    int     send_gap = 0;
    int     stall_cnt = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [7:0] clamp8(logic signed [31:0] v);
        if (v < 0) return 8'd0;
        if (v > 255) return 8'hFF;
        return v[7:0];
    endfunction

    function automatic logic [7:0] band_byte(logic signed [31:0] s, int b);
        logic signed [33:0] d;
        logic [63:0]        prod;
        if (!mode_reg[MODE_STRETCH]) return clamp8(s);
        d = {{2{s[31]}}, s} - {{2{low_reg[b][31]}}, low_reg[b]};
        if (d <= 0) return 8'd0;
        prod = {31'd0, d[32:0]} * {32'd0, gain_reg[b]};
        prod = prod >> FRAC_BITS;
        return (prod > 64'd255) ? 8'hFF : prod[7:0];
    endfunction

    function automatic logic [7:0] premul(logic [7:0] c, logic [7:0] a);
        logic [15:0] m;
        m = {8'd0, c} * {8'd0, a};
        return 8'(m / 16'd255);
    endfunction

    function automatic t_bgra predict_bgra(t_pixel p);
        t_bgra      res;
        logic [7:0] r, g, b, a;
        r = band_byte(p.red, 0);
        if (mode_reg[MODE_COLOR]) begin
            g = band_byte(p.green, 1);
            b = band_byte(p.blue, 2);
        end else begin
            g = r;
            b = r;
        end
        a = (mode_reg[MODE_NODATA] && p.red == nodata_reg) ? 8'd0 : 8'hFF;
        if (p.present) a = clamp8(p.alpha);
        res.blue  = premul(b, a);
        res.green = premul(g, a);
        res.red   = premul(r, a);
        res.alpha = a;
        return res;
    endfunction

    // Sender: hold the current transaction until taken, then offer the next pixel
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) bgra_q = {bgra_q, predict_bgra(cur_pix)};
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pix_q.size() > 0) begin
                    cur_pix = pix_q.pop_front();
                    s_axis_tdata  <= {cur_pix.alpha, cur_pix.blue, cur_pix.green, cur_pix.red};
                    s_axis_tuser  <= cur_pix.present;
                    s_axis_tvalid <= 1'b1;
                    if (gaps_on && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 16);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each output transaction, stall in random bursts
    always @(posedge i_clk) begin
        t_bgra      got, want;
        string      names[4];
        names = '{"blue", "green", "red", "alpha"};
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (bgra_q.size() == 0) begin
                    $display("%0t: unexpected pixel, expected none, actual %h", $time, got);
                    n_errors++;
                end else begin
                    want = bgra_q.pop_front();
                    for (int k = 0; k < 4; k++) begin
                        if (got[8*k +: 8] !== want[8*k +: 8]) begin
                            $display("%0t: %s mismatch, expected %h, actual %h",
                                     $time, names[k], want[8*k +: 8], got[8*k +: 8]);
                            n_errors++;
                        end
                    end
                end
            end
            if (hold_req != hold_done) begin
                hold_done++;
                stall_cnt = LONG_HOLD;
            end
            if (stall_cnt > 0) begin
                stall_cnt--;
                m_axis_tready <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 7) == 0) begin
                stall_cnt = $urandom_range(0, 15);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_MODE:       mode_reg = val[2:0];
            CFG_NODATA:     nodata_reg = val;
            CFG_RED_LOW:    low_reg[0] = val;
            CFG_RED_GAIN:   gain_reg[0] = val;
            CFG_GREEN_LOW:  low_reg[1] = val;
            CFG_GREEN_GAIN: gain_reg[1] = val;
            CFG_BLUE_LOW:   low_reg[2] = val;
            CFG_BLUE_GAIN:  gain_reg[2] = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic setup(logic [2:0] mode, logic [31:0] nodata, logic [31:0] rl, logic [31:0] rg,
                         logic [31:0] gl, logic [31:0] gg, logic [31:0] bl, logic [31:0] bg);
        write_reg(CFG_MODE, {29'd0, mode});
        write_reg(CFG_NODATA, nodata);
        write_reg(CFG_RED_LOW, rl);
        write_reg(CFG_RED_GAIN, rg);
        write_reg(CFG_GREEN_LOW, gl);
        write_reg(CFG_GREEN_GAIN, gg);
        write_reg(CFG_BLUE_LOW, bl);
        write_reg(CFG_BLUE_GAIN, bg);
        // Span of samples that the gain maps onto 0..255, for stimulus only
        for (int b = 0; b < 3; b++) begin
            span_reg[b] = (gain_reg[b] == 0) ? 1000 : 32'd16711680 / gain_reg[b];
            if (span_reg[b] == 0) span_reg[b] = 1;
        end
    endtask

    task automatic add_pix(logic [31:0] r, logic [31:0] g, logic [31:0] b,
                           logic [31:0] a, logic present);
        t_pixel p;
        p.red     = r;
        p.green   = g;
        p.blue    = b;
        p.alpha   = a;
        p.present = present;
        pix_q = {pix_q, p};
    endtask

    // Wait until every pixel is sent and every expected pixel has come back
    task automatic drain();
        while (pix_q.size() != 0 || s_axis_tvalid || bgra_q.size() != 0) @(negedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_sample(int b);
        int unsigned sp;
        sp = span_reg[b];
        case ($urandom_range(0, 9))
            0, 1:    return $urandom;
            2, 3:    return 32'($urandom_range(0, 320)) - 32'd20;
            default: return low_reg[b] + 32'($urandom_range(0, sp + sp / 4)) - 32'(sp / 8);
        endcase
    endfunction

    function automatic logic [31:0] pick_alpha();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return 32'($urandom_range(0, 340)) - 32'd40;
            default: return 32'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [31:0] pick_gain(int unsigned sp);
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return $urandom;
            default: return 32'd16711680 / sp;
        endcase
    endfunction

    function automatic logic [31:0] pick_low();
        return ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 2000)) - 32'd1000;
    endfunction

    task automatic random_phase(int n);
        logic [31:0] r;
        setup(3'($urandom_range(0, 7)), pick_low(),
              pick_low(), pick_gain($urandom_range(1, 4000)),
              pick_low(), pick_gain($urandom_range(1, 4000)),
              pick_low(), pick_gain($urandom_range(1, 4000)));
        for (int i = 0; i < n; i++) begin
            r = (mode_reg[MODE_NODATA] && $urandom_range(0, 5) == 0) ? nodata_reg : pick_sample(0);
            add_pix(r, pick_sample(1), pick_sample(2), pick_alpha(), 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: clamp only, gray, nodata check off
        add_pix(32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd0, 1'b0);
        add_pix(32'hFFFF_FFFF, 32'd255, 32'd256, 32'hFFFF_FFFF, 1'b1);
        add_pix(32'd255, 32'd254, 32'd1, 32'd256, 1'b1);
        add_pix(32'd200, 32'd100, 32'd50, 32'd128, 1'b1);
        add_pix(32'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        drain();

        // Color stretch with nodata: bounds, below-low, saturation, override
        setup(3'b111, -32'sd5, -32'sd100, 32'd16711680 / 400, 32'd1000, 32'd65536,
              32'h7FFF_FFFF, 32'hFFFF_FFFF);
        add_pix(-32'sd5, 32'd1500, 32'd0, 32'd0, 1'b0);
        add_pix(-32'sd5, 32'd1100, 32'd0, 32'd200, 1'b1);
        add_pix(-32'sd100, 32'd999, 32'h7FFF_FFFF, 32'd0, 1'b0);
        add_pix(32'd300, 32'd1255, 32'h8000_0000, 32'd0, 1'b0);
        add_pix(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd255, 1'b1);
        add_pix(32'd100, 32'd1128, 32'd5, 32'd77, 1'b1);
        drain();

        // Gray stretch at the widest span and largest gain
        setup(3'b101, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0,
              32'd0, 32'd0);
        add_pix(32'h7FFF_FFFF, 32'd7, 32'd9, 32'd0, 1'b0);
        add_pix(32'h8000_0000, 32'd7, 32'd9, 32'd0, 1'b0);
        add_pix(32'h8000_0001, 32'd7, 32'd9, 32'd0, 1'b0);
        add_pix(32'h8000_0000, 32'd7, 32'd9, 32'd77, 1'b1);
        drain();

        // Zero gain on every band
        setup(3'b011, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        add_pix(32'd1000, 32'h7FFF_FFFF, 32'd1, 32'd0, 1'b0);
        add_pix(32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
        drain();

        // Color without stretch, nodata check off
        setup(3'b010, 32'd40, 32'd0, 32'd65536, 32'd0, 32'd65536, 32'd0, 32'd65536);
        add_pix(32'd40, 32'd300, 32'hFFFF_FFF0, 32'd0, 1'b0);
        add_pix(32'd128, 32'd64, 32'd255, 32'd254, 1'b1);
        drain();

        for (int ph = 0; ph < 9; ph++) begin
            if (ph == 8) gaps_on = 1'b0;
            random_phase(42);
            // Stall the output long enough to back up the pipeline
            if (ph == 3) hold_req++;
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/rsp_pkg.sv
rtl/rsp_lane.sv
rtl/rsp_merge.sv
rtl/raster_stretch_to_premul_bgra.sv
tb/tb_top.sv
